### src/sorted_key_table_defines.svh
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define SKT_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define SKT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### src/skt_pkg.sv
package skt_pkg;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_SEARCH = 3'd2;
	localparam logic [2:0] CMD_REWIND = 3'd3;
	localparam logic [2:0] CMD_NEXT   = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_FULL   = 2'd1,
		STS_ABSENT = 2'd2,
		STS_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] key;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [15:0] item;
		logic [6:0]  count;
		logic        full_res;
		status_t     status;
	} rsp_t;

	typedef enum logic [2:0] {
		IDX_HOLD = 3'd0,
		IDX_TOP  = 3'd1,
		IDX_ZERO = 3'd2,
		IDX_INC  = 3'd3,
		IDX_DEC  = 3'd4
	} idx_op_t;

	typedef enum logic [1:0] {
		WA_ZERO = 2'd0,
		WA_UP   = 2'd1,
		WA_DOWN = 2'd2
	} wa_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2,
		CNT_CLR  = 2'd3
	} cnt_op_t;

	typedef enum logic [1:0] {
		ITEM_NONE  = 2'd0,
		ITEM_KEY   = 2'd1,
		ITEM_RDATA = 2'd2
	} item_sel_t;

	typedef struct packed {
		logic      latch;
		idx_op_t   idx_op;
		logic      rd_en;
		logic      rd_iter;
		logic      wr_en;
		logic      wr_key;
		wa_sel_t   wa_sel;
		cnt_op_t   cnt_op;
		logic      iter_rewind;
		logic      iter_step;
		logic      res_set;
		logic      res_found;
		item_sel_t res_item;
		status_t   res_status;
	} skt_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       full;
		logic       idx_zero;
		logic       idx_last;
		logic       lt;
		logic       eq;
	} skt_sts_t;

endpackage

### src/skt_ctrl.sv
module skt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            slot_free,
	output logic            load,
	output skt_pkg::skt_cmd_t cmd,
	input  skt_pkg::skt_sts_t sts
);
	import skt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_DISPATCH  = 8'b0000_0010,
		S_INS_WALK  = 8'b0000_0100,
		S_INS_LAST  = 8'b0000_1000,
		S_SCAN      = 8'b0001_0000,
		S_DEL_SHIFT = 8'b0010_0000,
		S_ITER_WAIT = 8'b0100_0000,
		S_RESP      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.res_set = 1'b1;
				state_d     = S_RESP;
				unique case (sts.op)
					CMD_INSERT: begin
						if (sts.full) begin
							cmd.res_status = STS_FULL;
						end else if (sts.empty) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_key = 1'b1;
							cmd.wa_sel = WA_ZERO;
							cmd.cnt_op = CNT_INC;
						end else begin
							cmd.res_set = 1'b0;
							cmd.idx_op  = IDX_TOP;
							cmd.rd_en   = 1'b1;
							state_d     = S_INS_WALK;
						end
					end
					CMD_DELETE, CMD_SEARCH: begin
						if (sts.empty) begin
							cmd.res_status = (sts.op == CMD_DELETE) ? STS_ABSENT : STS_OK;
						end else begin
							cmd.res_set = 1'b0;
							cmd.idx_op  = IDX_ZERO;
							cmd.rd_en   = 1'b1;
							state_d     = S_SCAN;
						end
					end
					CMD_REWIND: begin
						cmd.iter_rewind = 1'b1;
					end
					CMD_NEXT: begin
						if (sts.empty) begin
							cmd.res_status = STS_EMPTY;
						end else begin
							cmd.res_set   = 1'b0;
							cmd.iter_step = 1'b1;
							cmd.rd_en     = 1'b1;
							cmd.rd_iter   = 1'b1;
							state_d       = S_ITER_WAIT;
						end
					end
					CMD_CLEAR: begin
						cmd.cnt_op      = CNT_CLR;
						cmd.iter_rewind = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_INS_WALK: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_UP;
				if (sts.lt) begin
					cmd.wr_key  = 1'b1;
					cmd.cnt_op  = CNT_INC;
					cmd.res_set = 1'b1;
					state_d     = S_RESP;
				end else if (sts.idx_zero) begin
					state_d = S_INS_LAST;
				end else begin
					cmd.idx_op = IDX_DEC;
					cmd.rd_en  = 1'b1;
				end
			end
			S_INS_LAST: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_key  = 1'b1;
				cmd.wa_sel  = WA_ZERO;
				cmd.cnt_op  = CNT_INC;
				cmd.res_set = 1'b1;
				state_d     = S_RESP;
			end
			S_SCAN: begin
				if (sts.lt && !sts.idx_last) begin
					cmd.idx_op = IDX_INC;
					cmd.rd_en  = 1'b1;
				end else if (sts.eq) begin
					cmd.res_set   = 1'b1;
					cmd.res_found = 1'b1;
					if (sts.op == CMD_SEARCH) begin
						cmd.res_item = ITEM_KEY;
						state_d      = S_RESP;
					end else if (sts.idx_last) begin
						cmd.cnt_op = CNT_DEC;
						state_d    = S_RESP;
					end else begin
						cmd.idx_op = IDX_INC;
						cmd.rd_en  = 1'b1;
						state_d    = S_DEL_SHIFT;
					end
				end else begin
					cmd.res_set    = 1'b1;
					cmd.res_status = (sts.op == CMD_DELETE) ? STS_ABSENT : STS_OK;
					state_d        = S_RESP;
				end
			end
			S_DEL_SHIFT: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_DOWN;
				if (sts.idx_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_RESP;
				end else begin
					cmd.idx_op = IDX_INC;
					cmd.rd_en  = 1'b1;
				end
			end
			S_ITER_WAIT: begin
				cmd.res_set  = 1'b1;
				cmd.res_item = ITEM_RDATA;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (slot_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### src/skt_dp.sv
`include "sorted_key_table_defines.svh"

module skt_dp #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  skt_pkg::req_t     req,
	input  skt_pkg::skt_cmd_t cmd,
	output skt_pkg::skt_sts_t sts,
	output skt_pkg::rsp_t     res
);
	import skt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_WIDTH-1:0] mem_q [DEPTH];
	logic [KEY_WIDTH-1:0] rdata_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] wr_data;
	logic [2:0]           op_q;
	logic [AW-1:0]        idx_q, idx_d;
	logic [AW-1:0]        iter_pos_q, iter_d;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [CW-1:0]        cnt_q, idx_up;
	logic                 iter_started_q;
	logic                 found_q;
	logic [15:0]          item_q;
	status_t              status_q;

	assign idx_up = CW'(idx_q) + CW'(1);

	always_comb begin
		unique case (cmd.idx_op)
			IDX_HOLD: idx_d = idx_q;
			IDX_TOP:  idx_d = AW'(cnt_q - CW'(1));
			IDX_ZERO: idx_d = '0;
			IDX_INC:  idx_d = idx_q + AW'(1);
			IDX_DEC:  idx_d = idx_q - AW'(1);
			default:  idx_d = idx_q;
		endcase
	end

	always_comb begin
		priority if (!iter_started_q) begin
			iter_d = '0;
		end else if ((CW'(iter_pos_q) + CW'(1)) >= cnt_q) begin
			iter_d = '0;
		end else begin
			iter_d = iter_pos_q + AW'(1);
		end
	end

	assign rd_addr = cmd.rd_iter ? iter_d : idx_d;

	always_comb begin
		unique case (cmd.wa_sel)
			WA_ZERO: wr_addr = '0;
			WA_UP:   wr_addr = AW'(idx_up);
			WA_DOWN: wr_addr = idx_q - AW'(1);
			default: wr_addr = '0;
		endcase
	end

	assign wr_data = cmd.wr_key ? key_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (cmd.latch) begin
			op_q  <= req.cmd;
			key_q <= KEY_WIDTH'(req.key);
		end
		if (cmd.res_set) begin
			found_q  <= cmd.res_found;
			status_q <= cmd.res_status;
			unique case (cmd.res_item)
				ITEM_KEY:   item_q <= 16'(key_q);
				ITEM_RDATA: item_q <= 16'(rdata_q);
				default:    item_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			iter_pos_q     <= '0;
			iter_started_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_HOLD: cnt_q <= cnt_q;
				CNT_INC:  cnt_q <= cnt_q + CW'(1);
				CNT_DEC:  cnt_q <= cnt_q - CW'(1);
				CNT_CLR:  cnt_q <= '0;
				default:  cnt_q <= cnt_q;
			endcase
			if (cmd.iter_rewind) begin
				iter_pos_q     <= '0;
				iter_started_q <= 1'b0;
			end else if (cmd.iter_step) begin
				iter_pos_q     <= iter_d;
				iter_started_q <= 1'b1;
			end
		end
	end

	assign sts.op       = op_q;
	assign sts.empty    = (cnt_q == '0);
	assign sts.full     = (cnt_q == CW'(DEPTH));
	assign sts.idx_zero = (idx_q == '0);
	assign sts.idx_last = (idx_up == cnt_q);
	assign sts.lt       = (rdata_q < key_q);
	assign sts.eq       = (rdata_q == key_q);

	assign res.found    = found_q;
	assign res.item     = item_q;
	assign res.count    = 7'(cnt_q);
	assign res.full_res = (cnt_q == CW'(DEPTH));
	assign res.status   = status_q;

	`SKT_CHECK(a_cnt_range, cnt_q <= CW'(DEPTH), "key count above capacity")
	`SKT_IMPLY(a_inc_room, cmd.cnt_op == CNT_INC, cnt_q != CW'(DEPTH), "insert into full table")
	`SKT_IMPLY(a_rd_inside, cmd.rd_en, CW'(rd_addr) < cnt_q, "read beyond stored keys")
	`SKT_IMPLY(a_wr_inside, cmd.wr_en, CW'(wr_addr) <= cnt_q, "write beyond stored keys")

endmodule

### src/sorted_key_table.sv
// Sorted key table: holds up to DEPTH keys in ascending order (duplicates
// allowed) in a memory with one read and one write port, one command per
// transaction on req and exactly one result transaction on rsp. Insert, delete
// and search walk the stored keys one per clock, insert from the top down and
// delete and search from the bottom up; rewind, clear, get-next and an insert
// into a full table do not walk. The registered memory read sets that pace.
// A command is accepted only while no other command is in flight; a finished
// result waits in the output register while the next command is taken. Errors
// come back in status: insert while full, delete of an absent key, get-next on
// an empty table. count and full_res always describe the table after the command.
module sorted_key_table #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  skt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output skt_pkg::rsp_t rsp
);
	import skt_pkg::*;

	skt_cmd_t cmd;
	skt_sts_t sts;
	rsp_t     res;
	rsp_t     rsp_q;
	logic     rsp_valid_q;
	logic     slot_free;
	logic     load;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.slot_free (slot_free),
		.load      (load),
		.cmd       (cmd),
		.sts       (sts)
	);

	skt_dp #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
